/* rtl/core/lfbc_pkg.sv */
// ----------------------------------------------------------------------------
// lfbc_pkg: shared types, constants and tables for the led fade channel
// item structs, opcodes, register indexes, sequencer states, ease/cie/percent tables
// ----------------------------------------------------------------------------
package lfbc_pkg;

  localparam int unsigned TICKS_PER_SPEED_STEP = 10;
  localparam int unsigned EASE_TABLE_DEPTH     = 1024;
  localparam int unsigned EASE_IDX_W           = $clog2(EASE_TABLE_DEPTH);
  localparam int unsigned LEVEL_W              = 12;
  localparam int unsigned EASE_W               = 17;
  localparam int unsigned PCT_DEPTH            = 101;
  localparam int unsigned CIE_DEPTH            = 4096;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL    = 12'd4095;
  localparam longint unsigned PI_Q30           = 64'd3373259426;
  localparam longint unsigned EASE_U_DIV       = 64'd2 * 64'(EASE_TABLE_DEPTH);
  localparam longint unsigned CIE_D3           = 64'd118755 * 64'd118755 * 64'd118755;
  localparam longint unsigned CIE_DEN          = 64'd2 * CIE_D3;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_SET_TARGET  = 3'd1;
  localparam logic [2:0] OP_SET_LEVEL   = 3'd2;
  localparam logic [2:0] OP_SET_PERCENT = 3'd3;
  localparam logic [2:0] OP_ARM_DELAY   = 3'd4;

  localparam logic [2:0] REG_SPEED     = 3'd0;
  localparam logic [2:0] REG_MIN_LEVEL = 3'd1;
  localparam logic [2:0] REG_AUTO      = 3'd2;
  localparam logic [2:0] REG_PAUSE_ON  = 3'd3;
  localparam logic [2:0] REG_PAUSE_OFF = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] duty_corrected;
    logic [11:0] linear_level;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EASE,
    S_PROD,
    S_LERP,
    S_CIE,
    S_OUT
  } state_t;

  typedef logic [EASE_W-1:0]  ease_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef ease_t  ease_tab_t [EASE_TABLE_DEPTH];
  typedef level_t cie_tab_t  [CIE_DEPTH];
  typedef level_t pct_tab_t  [PCT_DEPTH];

  // sin^2(pi*k/(2*D)) in q16 from a q30 taylor sine
  function automatic longint unsigned ease_half(longint unsigned k);
    longint unsigned u, u2, u3, u5, u7, s, s2;
    u  = (PI_Q30 * k) / EASE_U_DIV;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u5 = (u3 * u2) >> 30;
    u7 = (u5 * u2) >> 30;
    s  = ((u - u3 / 64'd6) + u5 / 64'd120) - u7 / 64'd5040;
    s2 = (s * s) >> 30;
    return (s2 + 64'd8192) >> 14;
  endfunction

  function automatic ease_tab_t build_ease();
    ease_tab_t t;
    longint unsigned e;
    for (int i = 0; i < EASE_TABLE_DEPTH; i++) begin
      if (64'd2 * 64'(i) > 64'(EASE_TABLE_DEPTH)) begin
        e = 64'd65536 - ease_half(64'(EASE_TABLE_DEPTH) - 64'(i));
      end else begin
        e = ease_half(64'(i));
      end
      t[i] = e[EASE_W-1:0];
    end
    return t;
  endfunction

  function automatic cie_tab_t build_cie();
    cie_tab_t t;
    longint unsigned m, m3, r;
    for (int i = 0; i < CIE_DEPTH; i++) begin
      if (i <= 327) begin
        r = (64'(i) * 64'd2000 + 64'd9023) / 64'd18046;
      end else begin
        m  = 64'd25 * 64'(i) + 64'd16380;
        m3 = m * m * m;
        r  = (64'd2 * m3 * 64'd4095 + CIE_D3) / CIE_DEN;
        if (r > 64'd4095) begin
          r = 64'd4095;
        end
      end
      t[i] = r[LEVEL_W-1:0];
    end
    return t;
  endfunction

  function automatic pct_tab_t build_pct();
    pct_tab_t t;
    longint unsigned r;
    for (int i = 0; i < PCT_DEPTH; i++) begin
      r = (64'(i) * 64'd4095 + 64'd50) / 64'd100;
      t[i] = r[LEVEL_W-1:0];
    end
    return t;
  endfunction

  localparam ease_tab_t EASE_TAB = build_ease();
  localparam cie_tab_t  CIE_TAB  = build_cie();
  localparam pct_tab_t  PCT_TAB  = build_pct();

endpackage

/* rtl/core/led_fade_breathing_channel.sv */
// ----------------------------------------------------------------------------
// led_fade_breathing_channel: one led channel with eased fades
// raised-cosine fades, auto breathing with pauses, cie 1931 corrected output
// ----------------------------------------------------------------------------
// a tick inside a fade steps through S_MUL, S_DIV (the restoring divider that
// forms the ease index one quotient bit per cycle), S_EASE, S_PROD, S_LERP and
// S_CIE, then offers its result in S_OUT; set level, set percent and a tick that
// lands on the target go straight to S_CIE and S_OUT; other items give no result.
// in_ready stays low until the result transfer. synchronous active-low reset
// clears the control and config state to zero; datapath registers are not reset.
module led_fade_breathing_channel
  import lfbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned QW     = EASE_IDX_W;
  localparam int unsigned CNT_W  = $clog2(QW);
  localparam int unsigned PROD_W = 32 + QW;
  localparam int unsigned MP_W   = 30;

  state_t state_r, state_nxt;

  logic [15:0] speed_r, speed_nxt;
  logic [11:0] min_r, min_nxt;
  logic        auto_r, auto_nxt;
  logic [31:0] pon_r, pon_nxt;
  logic [31:0] poff_r, poff_nxt;

  logic [11:0] cur_r, cur_nxt;
  logic [11:0] tgt_r, tgt_nxt;
  logic [11:0] start_r, start_nxt;
  logic [11:0] remem_r, remem_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic [31:0] pcnt_r, pcnt_nxt;
  logic        prun_r, prun_nxt;
  logic [15:0] dcnt_r, dcnt_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic        dact_r, dact_nxt;

  logic [31:0]       rem_r, rem_nxt;
  logic [QW-1:0]     pbits_r, pbits_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  ease_t             ease_r, ease_nxt;
  logic [MP_W-1:0]   mprod_r, mprod_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic        acc;
  logic [31:0] el_inc, pc_inc, el_v, hold;
  logic        fade_go;
  logic [11:0] fade_dest, sat_v, dest_auto;
  logic        high, rising;
  logic [PROD_W-1:0] prod;
  logic [32:0] rem2;
  logic        ge;
  logic [11:0] span;
  logic [13:0] step;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign acc       = in_valid & in_ready;

  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    min_nxt       = min_r;
    auto_nxt      = auto_r;
    pon_nxt       = pon_r;
    poff_nxt      = poff_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    start_nxt     = start_r;
    remem_nxt     = remem_r;
    elapsed_nxt   = elapsed_r;
    dur_nxt       = dur_r;
    pcnt_nxt      = pcnt_r;
    prun_nxt      = prun_r;
    dcnt_nxt      = dcnt_r;
    dlen_nxt      = dlen_r;
    dact_nxt      = dact_r;
    rem_nxt       = rem_r;
    pbits_nxt     = pbits_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    ease_nxt      = ease_r;
    mprod_nxt     = mprod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    el_inc    = (elapsed_r != '1) ? elapsed_r + 32'd1 : elapsed_r;
    pc_inc    = (prun_r && pcnt_r != '1) ? pcnt_r + 32'd1 : pcnt_r;
    el_v      = el_inc;
    high      = tgt_r > min_r;
    hold      = high ? pon_r : poff_r;
    dest_auto = high ? min_r : remem_r;
    sat_v     = (in_data.value > 16'(FULL_LEVEL)) ? FULL_LEVEL : in_data.value[11:0];
    fade_go   = 1'b0;
    fade_dest = sat_v;
    prod      = PROD_W'(elapsed_r) * PROD_W'(EASE_TABLE_DEPTH);
    rem2      = {rem_r, pbits_r[QW-1]};
    ge        = rem2 >= {1'b0, dur_r};
    rising    = tgt_r >= start_r;
    span      = rising ? tgt_r - start_r : start_r - tgt_r;
    step      = mprod_r[MP_W-1:16];

    if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED:     speed_nxt = cfg_data[15:0];
        REG_MIN_LEVEL: min_nxt   = cfg_data[11:0];
        REG_AUTO:      auto_nxt  = cfg_data[0];
        REG_PAUSE_ON:  pon_nxt   = cfg_data;
        REG_PAUSE_OFF: poff_nxt  = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.opcode)
            OP_TICK: begin
              elapsed_nxt = el_inc;
              pcnt_nxt    = pc_inc;
              if (dact_r && dcnt_r < dlen_r) begin
                dcnt_nxt = dcnt_r + 16'd1;
              end else begin
                if (dact_r) begin
                  dact_nxt = 1'b0;
                  if (cur_r != tgt_r) el_v = '0;
                end
                elapsed_nxt = el_v;
                if (cur_r != tgt_r) begin
                  if (dur_r == '0 || el_v >= dur_r) begin
                    cur_nxt   = tgt_r;
                    state_nxt = S_CIE;
                  end else begin
                    state_nxt = S_MUL;
                  end
                end else if (auto_r) begin
                  fade_dest = dest_auto;
                  priority if (hold == '0) begin
                    fade_go = 1'b1;
                  end else if (!prun_r) begin
                    prun_nxt = 1'b1;
                    pcnt_nxt = '0;
                  end else if (pc_inc >= hold) begin
                    prun_nxt = 1'b0;
                    fade_go  = 1'b1;
                  end else begin
                    fade_go  = 1'b0;
                  end
                end
              end
            end
            OP_SET_TARGET: begin
              remem_nxt = sat_v;
              fade_go   = 1'b1;
            end
            OP_SET_LEVEL: begin
              cur_nxt   = sat_v;
              state_nxt = S_CIE;
            end
            OP_SET_PERCENT: begin
              cur_nxt   = (in_data.value > 16'd100) ? FULL_LEVEL
                                                    : PCT_TAB[in_data.value[6:0]];
              state_nxt = S_CIE;
            end
            OP_ARM_DELAY: begin
              dlen_nxt = in_data.value;
              dact_nxt = (in_data.value != '0);
              dcnt_nxt = '0;
            end
            default: ;
          endcase
          if (fade_go) begin
            start_nxt   = cur_r;
            tgt_nxt     = fade_dest;
            elapsed_nxt = '0;
            dur_nxt     = (fade_dest == cur_r) ? '0
                        : 32'(speed_r) * 32'(TICKS_PER_SPEED_STEP);
          end
        end
      end
      S_MUL: begin
        rem_nxt   = prod[QW+31:QW];
        pbits_nxt = prod[QW-1:0];
        cnt_nxt   = CNT_W'(QW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt   = ge ? 32'(rem2 - {1'b0, dur_r}) : rem2[31:0];
        pbits_nxt = pbits_r << 1;
        q_nxt     = {q_r[QW-2:0], ge};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = S_EASE;
      end
      S_EASE: begin
        ease_nxt  = EASE_TAB[q_r];
        state_nxt = S_PROD;
      end
      S_PROD: begin
        mprod_nxt = MP_W'(span) * MP_W'(ease_r) + (rising ? '0 : MP_W'(16'hFFFF));
        state_nxt = S_LERP;
      end
      S_LERP: begin
        cur_nxt   = rising ? start_r + step[11:0] : start_r - step[11:0];
        state_nxt = S_CIE;
      end
      S_CIE: begin
        out_data_nxt.duty_corrected = CIE_TAB[cur_r];
        out_data_nxt.linear_level   = cur_r;
        out_valid_nxt               = 1'b1;
        state_nxt                   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      speed_r     <= '0;
      min_r       <= '0;
      auto_r      <= 1'b0;
      pon_r       <= '0;
      poff_r      <= '0;
      cur_r       <= '0;
      tgt_r       <= '0;
      start_r     <= '0;
      remem_r     <= '0;
      elapsed_r   <= '0;
      dur_r       <= '0;
      pcnt_r      <= '0;
      prun_r      <= 1'b0;
      dcnt_r      <= '0;
      dlen_r      <= '0;
      dact_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      min_r       <= min_nxt;
      auto_r      <= auto_nxt;
      pon_r       <= pon_nxt;
      poff_r      <= poff_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      start_r     <= start_nxt;
      remem_r     <= remem_nxt;
      elapsed_r   <= elapsed_nxt;
      dur_r       <= dur_nxt;
      pcnt_r      <= pcnt_nxt;
      prun_r      <= prun_nxt;
      dcnt_r      <= dcnt_nxt;
      dlen_r      <= dlen_nxt;
      dact_r      <= dact_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    pbits_r    <= pbits_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    ease_r     <= ease_nxt;
    mprod_r    <= mprod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for led_fade_breathing_channel
// drives ticks and commands over valid/ready, predicts every level written
// (linear and cie corrected) and checks each output transfer in order
// ----------------------------------------------------------------------------
module tb;
  import lfbc_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  led_fade_breathing_channel DUT (.*);

  always #4 clk = ~clk;

  // predicted channel state
  logic [15:0] speed_r;
  level_t min_r;
  logic auto_r;
  logic [31:0] hold_hi_r, hold_lo_r;
  level_t lvl_now, lvl_goal, lvl_from, lvl_saved;
  logic [31:0] fade_t, fade_len, hold_t;
  logic holding;
  logic [15:0] wait_t, wait_len;
  logic waiting;

  out_item_t level_q[$];
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int n_items = 0;
  int n_levels = 0;
  int n_errors = 0;
  int stall = 0;

  function automatic level_t clip(longint unsigned v);
    return (v > 4095) ? 12'd4095 : v[11:0];
  endfunction

  function automatic level_t cie_duty(level_t lin);
    longint unsigned m, m3, d3;
    if (lin <= 327) return 12'((64'(lin) * 2000 + 9023) / 18046);
    m = 25 * 64'(lin) + 16380;
    m3 = m * m * m;
    d3 = 64'd118755 * 64'd118755 * 64'd118755;
    return clip((2 * m3 * 4095 + d3) / (2 * d3));
  endfunction

  function automatic longint unsigned sine_sq_q16(longint unsigned k);
    longint unsigned u, u2, u3, u5, u7, s;
    u = (64'd3373259426 * k) / 2048;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u5 = (u3 * u2) >> 30;
    u7 = (u5 * u2) >> 30;
    s = ((u - u3 / 6) + u5 / 120) - u7 / 5040;
    return (((s * s) >> 30) + 8192) >> 14;
  endfunction

  function automatic void start_fade(level_t dest);
    lvl_from = lvl_now;
    lvl_goal = dest;
    fade_t = 0;
    fade_len = (dest == lvl_now) ? 32'd0 : 32'(speed_r) * 32'd10;
  endfunction

  function automatic void advance_tick(output logic hit, output level_t lv);
    longint unsigned idx, e, d;
    logic hi_end;
    logic [31:0] hold;
    level_t dest;
    hit = 1'b0;
    lv = '0;
    if (fade_t != 32'hFFFF_FFFF) fade_t++;
    if (holding && hold_t != 32'hFFFF_FFFF) hold_t++;
    if (waiting) begin
      if (wait_t < wait_len) begin
        wait_t++;
        return;
      end
      waiting = 1'b0;
      if (lvl_now != lvl_goal) fade_t = 0;
    end
    if (lvl_now != lvl_goal) begin
      hit = 1'b1;
      if (fade_len == 0 || fade_t >= fade_len) begin
        lv = lvl_goal;
        return;
      end
      idx = (64'(fade_t) * 1024) / 64'(fade_len);
      e = (2 * idx > 1024) ? 65536 - sine_sq_q16(1024 - idx) : sine_sq_q16(idx);
      if (lvl_goal >= lvl_from) begin
        d = 64'(lvl_goal - lvl_from);
        lv = lvl_from + 12'((d * e) >> 16);
      end else begin
        d = 64'(lvl_from - lvl_goal);
        lv = lvl_from - 12'((d * e + 65535) >> 16);
      end
      return;
    end
    if (auto_r) begin
      hi_end = lvl_goal > min_r;
      hold = hi_end ? hold_hi_r : hold_lo_r;
      dest = hi_end ? min_r : lvl_saved;
      if (hold == 0) begin
        start_fade(dest);
      end else if (!holding) begin
        holding = 1'b1;
        hold_t = 0;
      end else if (hold_t >= hold) begin
        holding = 1'b0;
        start_fade(dest);
      end
    end
  endfunction

  function automatic void predict_level(in_item_t it);
    logic hit;
    level_t lv;
    hit = 1'b0;
    lv = '0;
    case (it.opcode)
      OP_TICK: advance_tick(hit, lv);
      OP_SET_TARGET: begin
        lvl_saved = clip(64'(it.value));
        start_fade(lvl_saved);
      end
      OP_SET_LEVEL: begin
        hit = 1'b1;
        lv = clip(64'(it.value));
      end
      OP_SET_PERCENT: begin
        hit = 1'b1;
        lv = clip((64'(it.value) * 4095 + 50) / 100);
      end
      OP_ARM_DELAY: begin
        wait_len = it.value;
        waiting = it.value != 0;
        wait_t = '0;
      end
      default: ;
    endcase
    if (hit) begin
      lvl_now = lv;
      level_q.push_back(out_item_t'{duty_corrected: cie_duty(lv), linear_level: lv});
    end
  endfunction

  task automatic send_item(logic [2:0] op, logic [15:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_level('{opcode: op, value: val});
    n_items++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
  endtask

  // hold off the sender until all levels are back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPEED: speed_r = val[15:0];
      REG_MIN_LEVEL: min_r = val[11:0];
      REG_AUTO: auto_r = val[0];
      REG_PAUSE_ON: hold_hi_r = val;
      REG_PAUSE_OFF: hold_lo_r = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup_regs(logic [15:0] spd, level_t lo, logic auto_on,
                            logic [31:0] p_on, logic [31:0] p_off);
    drain();
    write_reg(REG_SPEED, 32'(spd));
    write_reg(REG_MIN_LEVEL, 32'(lo));
    write_reg(REG_AUTO, 32'(auto_on));
    write_reg(REG_PAUSE_ON, p_on);
    write_reg(REG_PAUSE_OFF, p_off);
  endtask

  task automatic test_directed();
    setup_regs(16'd0, 12'd0, 1'b0, 32'd0, 32'd0);
    send_item(OP_SET_LEVEL, 16'd0);
    send_item(OP_SET_LEVEL, 16'd4095);
    send_item(OP_SET_LEVEL, 16'hFFFF);
    send_item(OP_SET_PERCENT, 16'd0);
    send_item(OP_SET_PERCENT, 16'd50);
    send_item(OP_SET_PERCENT, 16'd100);
    send_item(OP_SET_PERCENT, 16'd101);
    send_item(OP_SET_PERCENT, 16'hFFFF);
    send_item(OP_SPARE_LO, 16'hFFFF);
    send_item(OP_SPARE_MID, 16'h5555);
    send_item(OP_SPARE_HI, 16'hAAAA);
    send_item(OP_SET_TARGET, 16'd4096);
    send_item(OP_SET_TARGET, 16'd4095);
    send_item(OP_ARM_DELAY, 16'd2);
    send_item(OP_SET_TARGET, 16'd0);
    send_ticks(4);
    send_item(OP_ARM_DELAY, 16'd0);
    send_item(OP_TICK, 16'd0);
    // set level in mid fade, the old fade resumes
    setup_regs(16'd1, 12'd0, 1'b0, 32'd0, 32'd0);
    send_item(OP_SET_TARGET, 16'd2000);
    send_ticks(3);
    send_item(OP_SET_LEVEL, 16'd100);
    send_ticks(10);
  endtask

  task automatic test_fades(int n);
    int k;
    int cfg_at;
    int n_t;
    k = 0;
    cfg_at = 0;
    while (k < n) begin
      if (k >= cfg_at) begin
        setup_regs(($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535))
                   : 16'($urandom_range(0, 4)), 12'd0, 1'b0, 32'd0, 32'd0);
        cfg_at = k + 100;
      end
      case ($urandom_range(9))
        0: send_item(OP_SET_LEVEL, 16'($urandom_range(0, 65535)));
        1: send_item(OP_SET_PERCENT, ($urandom_range(3) == 0) ?
                     16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 101)));
        2: send_item(OP_ARM_DELAY, 16'($urandom_range(0, 6)));
        3: send_item(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        default: begin
          send_item(OP_SET_TARGET, ($urandom_range(7) == 0) ?
                    16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4095)));
          n_t = int'($urandom_range(1, 12));
          send_ticks(n_t);
          k += n_t;
        end
      endcase
      k++;
    end
  endtask

  task automatic test_auto(int n);
    int k;
    k = 0;
    while (k < n) begin
      setup_regs(16'($urandom_range(0, 2)), 12'($urandom_range(0, 4095)), 1'b1,
                 32'($urandom_range(0, 12)), 32'($urandom_range(0, 12)));
      send_item(OP_SET_TARGET, 16'($urandom_range(0, 4095)));
      repeat (50) begin
        if ($urandom_range(24) == 0) send_item(OP_ARM_DELAY, 16'($urandom_range(0, 5)));
        else send_item(OP_TICK, 16'($urandom_range(0, 65535)));
        k++;
      end
    end
  endtask

  task automatic test_extremes();
    setup_regs(16'hFFFF, 12'd4095, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_SET_TARGET, 16'd4095);
    send_ticks(20);
    send_item(OP_ARM_DELAY, 16'hFFFF);
    send_ticks(5);
    setup_regs(16'd0, 12'd4095, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_ARM_DELAY, 16'd0);
    send_item(OP_SET_TARGET, 16'd0);
    send_ticks(10);
    send_item(OP_SET_LEVEL, 16'd4095);
    send_ticks(10);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_levels++;
      if (level_q.size() == 0) begin
        $error("unexpected output transfer: duty %0d linear %0d",
               out_data.duty_corrected, out_data.linear_level);
        n_errors++;
      end else begin
        want = level_q.pop_front();
        if (out_data.duty_corrected !== want.duty_corrected) begin
          $error("duty_corrected expected %0d actual %0d",
                 want.duty_corrected, out_data.duty_corrected);
          n_errors++;
        end
        if (out_data.linear_level !== want.linear_level) begin
          $error("linear_level expected %0d actual %0d",
                 want.linear_level, out_data.linear_level);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall == STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    speed_r = '0; min_r = '0; auto_r = 1'b0; hold_hi_r = '0; hold_lo_r = '0;
    lvl_now = '0; lvl_goal = '0; lvl_from = '0; lvl_saved = '0;
    fade_t = '0; fade_len = '0; hold_t = '0; holding = 1'b0;
    wait_t = '0; wait_len = '0; waiting = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 3; p++) begin
      in_idle_pct = (p == 0) ? 36 : (p == 1) ? 88 : 0;
      out_idle_pct = (p == 0) ? 88 : (p == 1) ? 36 : 0;
      test_fades(280);
      test_auto(200);
    end
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_extremes();
    drain();
    $display("covered %0d input items and %0d levels: fades, delays, breathing",
             n_items, n_levels);
    $display("with pauses, saturation, spare opcodes and register extremes");
    if (n_errors == 0 && level_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lfbc_pkg.sv
rtl/core/led_fade_breathing_channel.sv
tb/tb.sv
